// ===== hdl/lr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the line rasterizer.
// Used by lr_ctrl, lr_datapath and line_rasterizer; depends on nothing.

package lr_pkg;

    localparam int COORD_BITS_DEF = 6;
    localparam int COLOR_BITS_DEF = 32;

    // Longest line the block will draw; a longer one is cut at this pixel.
    localparam int MAX_PIXELS = 64;
    localparam int CNT_W      = $clog2(MAX_PIXELS);

    typedef enum logic
    {
        ST_IDLE,
        ST_DRAW
    } lr_state_t;

    typedef struct packed
    {
        logic load;
        logic step;
    } lr_cmd_t;

    typedef struct packed
    {
        logic stop;
    } lr_status_t;

endpackage

// ===== hdl/line_rasterizer.sv =====
`timescale 1ns / 1ps
// Top level of the line rasterizer: joins the controller and the datapath.
// Depends on lr_pkg, lr_ctrl and lr_datapath.

// A line command (start point, end point, color) is taken while the block is
// idle, and the pixels of the line then come out one word per cycle, in order
// from the start point, each carrying the command's color; the final word has
// last_pixel set. The command is loaded first, and each pixel then steps through
// the error-step register of the datapath. A stalled output pauses the stepping,
// and the next command may be taken while the final pixel still waits in the
// output register.

module line_rasterizer
#(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
    parameter int COLOR_BITS = lr_pkg::COLOR_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic [COLOR_BITS-1:0] line_color,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic [COLOR_BITS-1:0] pixel_color,
    output logic                  last_pixel
);

    lr_pkg::lr_cmd_t    cmd;
    lr_pkg::lr_status_t status;

    lr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    lr_datapath
    #(
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .line_color  (line_color),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

endmodule

// ===== hdl/lr_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the line rasterizer: command acceptance, pixel emission and
// output valid tracking. Depends on lr_pkg.

module lr_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output lr_pkg::lr_cmd_t    cmd,
    input  lr_pkg::lr_status_t status
);

    lr_pkg::lr_state_t state_reg;
    lr_pkg::lr_state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lr_pkg::ST_DRAW;
                end
            end
            lr_pkg::ST_DRAW:
            begin
                if (slot_free && status.stop)
                begin
                    state_next = lr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load = 1'b0;
        cmd.step = 1'b0;
        in_ready = 1'b0;
        unique case (state_reg)
            lr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            lr_pkg::ST_DRAW:
            begin
                cmd.step = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // A word leaves the output register when taken; a new pixel refills it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_load_starts_draw: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == lr_pkg::ST_DRAW)
        else $error("load did not start a line");

    a_last_ends_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && status.stop) |=> (state_reg == lr_pkg::ST_IDLE && out_valid_reg))
        else $error("final pixel did not return to idle");

    a_draw_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lr_pkg::ST_DRAW && !(cmd.step && status.stop))
            |=> state_reg == lr_pkg::ST_DRAW)
        else $error("line ended without a final pixel");

endmodule

// ===== hdl/lr_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the line rasterizer: Bresenham error stepping, pixel counter
// and the output word register. Depends on lr_pkg.

module lr_datapath
#(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
    parameter int COLOR_BITS = lr_pkg::COLOR_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lr_pkg::lr_cmd_t       cmd,
    output lr_pkg::lr_status_t    status,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic [COLOR_BITS-1:0] line_color,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic [COLOR_BITS-1:0] pixel_color,
    output logic                  last_pixel
);

    localparam int DX_W  = COORD_BITS + 1;
    localparam int DY_W  = COORD_BITS + 2;
    localparam int ERR_W = COORD_BITS + 3;
    localparam int E2_W  = COORD_BITS + 4;

    logic [COORD_BITS-1:0]   cur_x_reg;
    logic [COORD_BITS-1:0]   cur_y_reg;
    logic [COORD_BITS-1:0]   target_x_reg;
    logic [COORD_BITS-1:0]   target_y_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [DX_W-1:0]  delta_x_reg;
    logic signed [DY_W-1:0]  delta_y_neg_reg;
    logic                    step_x_neg_reg;
    logic                    step_y_neg_reg;
    logic [COLOR_BITS-1:0]   color_reg;
    logic [lr_pkg::CNT_W-1:0] count_reg;

    logic [COORD_BITS-1:0]   pix_x_reg;
    logic [COORD_BITS-1:0]   pix_y_reg;
    logic [COLOR_BITS-1:0]   pix_color_reg;
    logic                    pix_last_reg;

    logic [COORD_BITS-1:0]   diff_x;
    logic [COORD_BITS-1:0]   diff_y;
    logic signed [DX_W-1:0]  load_dx;
    logic signed [DY_W-1:0]  load_dy_neg;
    logic signed [E2_W-1:0]  e2;
    logic                    move_x;
    logic                    move_y;
    logic                    x_done;
    logic                    y_done;
    logic                    stop;
    logic signed [ERR_W-1:0] err_next;
    logic [COORD_BITS-1:0]   cur_x_next;
    logic [COORD_BITS-1:0]   cur_y_next;

    assign diff_x      = (end_x >= start_x) ? (end_x - start_x) : (start_x - end_x);
    assign diff_y      = (end_y >= start_y) ? (end_y - start_y) : (start_y - end_y);
    assign load_dx     = $signed({1'b0, diff_x});
    assign load_dy_neg = -$signed({2'b00, diff_y});

    assign e2     = $signed({err_reg, 1'b0});
    assign move_x = e2 >= E2_W'(delta_y_neg_reg);
    assign move_y = e2 <= E2_W'(delta_x_reg);
    assign x_done = cur_x_reg == target_x_reg;
    assign y_done = cur_y_reg == target_y_reg;

    // The line ends at the end point, or when a step would run along an axis
    // that has already arrived, or when the pixel cap is hit.
    assign stop = (x_done && y_done) || (move_x && x_done) || (move_y && y_done)
                  || (count_reg == lr_pkg::CNT_W'(lr_pkg::MAX_PIXELS - 1));

    assign status.stop = stop;

    always_comb
    begin
        err_next   = err_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        if (move_x)
        begin
            cur_x_next = step_x_neg_reg ? (cur_x_reg - 1'b1) : (cur_x_reg + 1'b1);
        end
        if (move_y)
        begin
            cur_y_next = step_y_neg_reg ? (cur_y_reg - 1'b1) : (cur_y_reg + 1'b1);
        end
        err_next = err_reg + (move_x ? ERR_W'(delta_y_neg_reg) : ERR_W'(0))
                           + (move_y ? ERR_W'(delta_x_reg) : ERR_W'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            color_reg       <= '0;
            delta_x_reg     <= '0;
            delta_y_neg_reg <= '0;
            step_x_neg_reg  <= 1'b0;
            step_y_neg_reg  <= 1'b0;
            err_reg         <= '0;
            pix_x_reg       <= '0;
            pix_y_reg       <= '0;
            pix_color_reg   <= '0;
            pix_last_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cur_x_reg       <= start_x;
                cur_y_reg       <= start_y;
                target_x_reg    <= end_x;
                target_y_reg    <= end_y;
                color_reg       <= line_color;
                delta_x_reg     <= load_dx;
                delta_y_neg_reg <= load_dy_neg;
                step_x_neg_reg  <= !(start_x < end_x);
                step_y_neg_reg  <= !(start_y < end_y);
                err_reg         <= ERR_W'(load_dx) + ERR_W'(load_dy_neg);
            end
            else if (cmd.step)
            begin
                cur_x_reg <= cur_x_next;
                cur_y_reg <= cur_y_next;
                err_reg   <= err_next;
            end
            if (cmd.step)
            begin
                pix_x_reg     <= cur_x_reg;
                pix_y_reg     <= cur_y_reg;
                pix_color_reg <= color_reg;
                pix_last_reg  <= stop;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.load)
        begin
            count_reg <= '0;
        end
        else if (cmd.step && !stop)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    assign pixel_x     = pix_x_reg;
    assign pixel_y     = pix_y_reg;
    assign pixel_color = pix_color_reg;
    assign last_pixel  = pix_last_reg;

endmodule
